>>> rtl/core/iarc_pkg.sv
// shared types, constants and helpers for the insulation resistance core
`timescale 1ns / 1ps

package iarc_pkg;

  localparam int unsigned POINTS_PER_RANGE = 10;
  localparam int unsigned RANGE_COUNT      = 4;
  localparam int unsigned ADC_W            = 12;
  localparam int unsigned VOLT_W           = 16;
  localparam int unsigned OPEN_LIMIT       = 10;
  localparam logic [31:0] ALL_ONES         = 32'hFFFF_FFFF;

  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_MEASURE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OPEN = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [2:0]         range_sel;
    logic [3:0]         point_index;
    logic [VOLT_W-1:0]  cal_voltage;
    logic [ADC_W-1:0]   cal_adc;
    logic [2:0]         gear;
    logic [VOLT_W-1:0]  test_voltage;
    logic [ADC_W-1:0]   adc_sample;
  } cmd_t;

  typedef struct packed {
    logic [31:0] resistance;
    status_t     status;
  } res_t;

  // gear to zero-based range, clamped to the ranges present
  function automatic logic [2:0] range_index(logic [2:0] gear, int unsigned count);
    logic [2:0] r;
    if (gear == 3'd0) begin
      r = 3'd1;
    end else if (gear <= 3'd4) begin
      r = gear;
    end else if (gear == 3'd5) begin
      r = 3'd4;
    end else begin
      r = 3'd3;
    end
    if (int'(r) > int'(count)) begin
      r = 3'(count);
    end
    return r - 3'd1;
  endfunction

  // full-scale multiplier of each range: 200 * 10^k
  function automatic logic [31:0] range_base(logic [2:0] rng);
    logic [31:0] b;
    case (rng)
      3'd0:    b = 32'd200;
      3'd1:    b = 32'd2000;
      3'd2:    b = 32'd20000;
      3'd3:    b = 32'd200000;
      3'd4:    b = 32'd2000000;
      3'd5:    b = 32'd20000000;
      3'd6:    b = 32'd200000000;
      default: b = 32'd2000000000;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/core/insulation_resistance_calibrated_core.sv
// top level: calibration table, segment search, shared multiplier and serial divider
`timescale 1ns / 1ps

// Converts a test voltage and a current-sense ADC sample into a resistance by
// piecewise-linear interpolation over a per-range table of calibration points.
// A write beat stores one point, with no result; a bad address is ignored. A
// measure beat gives exactly one result beat: an open reading is flagged from
// idle; otherwise the table is scanned one point at a time (a memory read, then
// a compare), then S_MUL_A to S_MUL_D on the single shared 32x32 multiplier,
// the overflow check and the one-bit-per-cycle restoring divider follow, unless
// a bad denominator or overflow saturates first. The block takes a new beat only
// when its sequencer is idle and no result waits for the output register; a
// finished result waits in the output register without holding up the next beat.

module insulation_resistance_calibrated_core #(
  parameter int unsigned POINTS_PER_RANGE = iarc_pkg::POINTS_PER_RANGE,
  parameter int unsigned RANGE_COUNT      = iarc_pkg::RANGE_COUNT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  iarc_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_ready,
  output iarc_pkg::res_t res
);

  localparam int unsigned DEPTH  = RANGE_COUNT * POINTS_PER_RANGE;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IW     = (POINTS_PER_RANGE > 1) ? $clog2(POINTS_PER_RANGE) : 1;
  localparam int unsigned VW     = iarc_pkg::VOLT_W;
  localparam int unsigned AD     = iarc_pkg::ADC_W;
  localparam int unsigned MW     = VW + AD;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_READ  = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_MUL_A = 9'b000001000,
    S_MUL_B = 9'b000010000,
    S_MUL_C = 9'b000100000,
    S_MUL_D = 9'b001000000,
    S_OVF   = 9'b010000000,
    S_DIV   = 9'b100000000
  } state_t;

  state_t state;
  logic   done_pend;

  logic [MW-1:0] cal_mem [DEPTH];
  logic [MW-1:0] rd_data;
  logic [AW-1:0] addr;
  logic [AW-1:0] waddr;
  logic          wen;

  logic [IW-1:0] idx;
  logic [2:0]    rng;
  logic [VW-1:0] volt;
  logic [AD-1:0] adc;
  logic [VW-1:0] v1;
  logic [VW-1:0] v2;
  logic [AD-1:0] a1;
  logic [AD-1:0] a2;

  logic signed [AD:0]   dad;
  logic signed [VW:0]   dv;
  logic signed [AD:0]   dx;
  logic [AD-1:0]        dad_abs;
  logic signed [31:0]   mul_a;
  logic signed [31:0]   mul_b;
  logic signed [63:0]   prod;
  logic signed [31:0]   acc;
  logic signed [31:0]   den_sum;
  logic signed [31:0]   den;
  logic [31:0]          rem;
  logic [31:0]          quo;
  logic [4:0]           cnt;
  logic [32:0]          div_trial;
  logic [31:0]          rem_next;
  logic [31:0]          quo_next;

  logic [31:0]          out_res;
  iarc_pkg::status_t    out_st;

  logic [VW-1:0] rd_volt;
  logic [AD-1:0] rd_adc;
  logic          cmd_fire;
  logic          cmd_write_ok;

  assign rd_volt   = rd_data[MW-1:AD];
  assign rd_adc    = rd_data[AD-1:0];
  assign cmd_ready = (state == S_IDLE) && !done_pend;
  assign cmd_fire  = cmd_valid && cmd_ready;

  assign cmd_write_ok = (cmd.range_sel != 3'd0) && (int'(cmd.range_sel) <= int'(RANGE_COUNT))
                     && (int'(cmd.point_index) < int'(POINTS_PER_RANGE));
  assign wen   = cmd_fire && (cmd.func == iarc_pkg::FUNC_WRITE) && cmd_write_ok;
  assign waddr = AW'((int'(cmd.range_sel) - 1) * int'(POINTS_PER_RANGE)
                     + int'(cmd.point_index));

  // calibration table
  always_ff @(posedge clk) begin
    if (wen) begin
      cal_mem[waddr] <= {cmd.cal_voltage, cmd.cal_adc};
    end
    rd_data <= cal_mem[addr];
  end

  // segment geometry
  assign dad     = $signed({1'b0, a2}) - $signed({1'b0, a1});
  assign dv      = $signed({1'b0, v2}) - $signed({1'b0, v1});
  assign dx      = $signed({1'b0, adc}) - $signed({1'b0, a1});
  assign dad_abs = dad[AD] ? AD'(-dad) : AD'(dad);
  assign den_sum = acc + prod[31:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_A: begin
        mul_a = $signed({16'b0, v1});
        mul_b = 32'(dad);
      end
      S_MUL_B: begin
        mul_a = 32'(dv);
        mul_b = 32'(dx);
      end
      S_MUL_C: begin
        mul_a = $signed({16'b0, volt});
        mul_b = $signed({{(32-AD){1'b0}}, dad_abs});
      end
      S_MUL_D: begin
        mul_a = prod[31:0];
        mul_b = $signed(iarc_pkg::range_base(rng));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // one restoring divide step
  assign div_trial = {rem, quo[31]} - {1'b0, den};
  assign rem_next  = div_trial[32] ? {rem[30:0], quo[31]} : div_trial[31:0];
  assign quo_next  = {quo[30:0], ~div_trial[32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done_pend <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (done_pend && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
        done_pend <= 1'b0;
        res       <= '{resistance: out_res, status: out_st};
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_fire && cmd.func == iarc_pkg::FUNC_MEASURE) begin
            volt <= cmd.test_voltage;
            adc  <= cmd.adc_sample;
            rng  <= iarc_pkg::range_index(cmd.gear, RANGE_COUNT);
            if (cmd.gear != 3'd0 && cmd.adc_sample <= AD'(iarc_pkg::OPEN_LIMIT)) begin
              out_res   <= iarc_pkg::ALL_ONES;
              out_st    <= iarc_pkg::ST_OPEN;
              done_pend <= 1'b1;
            end else begin
              addr  <= AW'(int'(iarc_pkg::range_index(cmd.gear, RANGE_COUNT))
                           * int'(POINTS_PER_RANGE));
              idx   <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (idx == '0) begin
            if (adc <= rd_adc) begin
              v1    <= '0;
              a1    <= '0;
              v2    <= rd_volt;
              a2    <= rd_adc;
              state <= S_MUL_A;
            end else begin
              v1    <= rd_volt;
              a1    <= rd_adc;
              idx   <= idx + 1'b1;
              addr  <= addr + 1'b1;
              state <= S_READ;
            end
          end else if (adc < rd_adc || idx == IW'(POINTS_PER_RANGE - 1)) begin
            v2    <= rd_volt;
            a2    <= rd_adc;
            state <= S_MUL_A;
          end else begin
            v1    <= rd_volt;
            a1    <= rd_adc;
            idx   <= idx + 1'b1;
            addr  <= addr + 1'b1;
            state <= S_READ;
          end
        end
        S_MUL_A: begin
          prod  <= mul_a * mul_b;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= prod[31:0];
          prod  <= mul_a * mul_b;
          state <= S_MUL_C;
        end
        S_MUL_C: begin
          den   <= dad[AD] ? -den_sum : den_sum;
          prod  <= mul_a * mul_b;
          state <= S_MUL_D;
        end
        S_MUL_D: begin
          if (dad == '0 || den <= 0) begin
            out_res   <= iarc_pkg::ALL_ONES;
            out_st    <= iarc_pkg::ST_SAT;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            prod  <= mul_a * mul_b;
            state <= S_OVF;
          end
        end
        S_OVF: begin
          // quotient fits 32 bits only if the upper dividend half is below the divisor
          if (prod[63:32] >= den) begin
            out_res   <= iarc_pkg::ALL_ONES;
            out_st    <= iarc_pkg::ST_SAT;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end else begin
            rem   <= prod[63:32];
            quo   <= prod[31:0];
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 1'b1;
          if (cnt == 5'd31) begin
            out_res   <= quo_next;
            out_st    <= iarc_pkg::ST_OK;
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("sequencer state not one-hot");

  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> (den > 0) && (rem < den))
    else $error("divider invariant broken");

  assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.func == iarc_pkg::FUNC_WRITE |=> state == S_IDLE && !done_pend)
    else $error("write beat started a measurement");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != iarc_pkg::ST_OK |-> res.resistance == iarc_pkg::ALL_ONES)
    else $error("flagged result not all ones");

  assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> int'(idx) < int'(POINTS_PER_RANGE))
    else $error("segment search ran past the table");

endmodule

>>> sim/iarc_resistance_checker.sv
// checker: predicts each measurement result from the command beats and compares the result beats
`timescale 1ns / 1ps

module iarc_resistance_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_ready,
  input  iarc_pkg::cmd_t cmd,
  input  logic           res_valid,
  input  logic           res_ready,
  input  iarc_pkg::res_t res,
  output int             errors,
  output int             pending
);

  localparam int unsigned TABLE_DEPTH = iarc_pkg::RANGE_COUNT * iarc_pkg::POINTS_PER_RANGE;
  localparam longint unsigned BASE_LOW = 200;

  logic [iarc_pkg::VOLT_W-1:0] volt_tab [TABLE_DEPTH];
  logic [iarc_pkg::ADC_W-1:0]  adc_tab  [TABLE_DEPTH];
  iarc_pkg::res_t              resistance_q [$];

  function automatic iarc_pkg::res_t calc_resistance(input iarc_pkg::cmd_t c);
    int unsigned     rng;
    int unsigned     off;
    int unsigned     i;
    longint          v1, v2, a1, a2, dad, dv, den, adc;
    longint unsigned num, quo, base;
    iarc_pkg::res_t  r;
    r.resistance = iarc_pkg::ALL_ONES;
    r.status     = iarc_pkg::ST_SAT;
    adc = c.adc_sample;
    if (c.gear != 3'd0 && adc <= iarc_pkg::OPEN_LIMIT) begin
      r.status = iarc_pkg::ST_OPEN;
      return r;
    end
    case (c.gear)
      3'd0:                rng = 1;
      3'd1, 3'd2, 3'd3, 3'd4: rng = c.gear;
      3'd5:                rng = 4;
      default:             rng = 3;
    endcase
    if (rng > iarc_pkg::RANGE_COUNT) rng = iarc_pkg::RANGE_COUNT;
    off = (rng - 1) * iarc_pkg::POINTS_PER_RANGE;
    if (adc <= adc_tab[off]) begin
      v1 = 0;
      a1 = 0;
      v2 = volt_tab[off];
      a2 = adc_tab[off];
    end else begin
      i = 0;
      while (i < iarc_pkg::POINTS_PER_RANGE && adc >= adc_tab[off + i]) i++;
      if (i == iarc_pkg::POINTS_PER_RANGE) i = iarc_pkg::POINTS_PER_RANGE - 1;
      v1 = volt_tab[off + i - 1];
      a1 = adc_tab[off + i - 1];
      v2 = volt_tab[off + i];
      a2 = adc_tab[off + i];
    end
    dad = a2 - a1;
    dv  = v2 - v1;
    den = v1 * dad + dv * (adc - a1);
    // falling segment: flip both signs
    if (dad < 0) begin
      dad = -dad;
      den = -den;
    end
    if (dad == 0 || den <= 0) return r;
    base = BASE_LOW;
    repeat (rng - 1) base = base * 10;
    num = c.test_voltage;
    num = num * base;
    num = num * dad;
    quo = num / den;
    if (quo > 64'h0000_0000_FFFF_FFFF) return r;
    r.resistance = quo[31:0];
    r.status     = iarc_pkg::ST_OK;
    return r;
  endfunction

  always @(posedge clk) begin
    iarc_pkg::res_t want;
    int unsigned    idx;
    if (rst) begin
      resistance_q.delete();
      pending <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (resistance_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) begin
            $display("unexpected result beat: resistance %h status %0d",
                     res.resistance, res.status);
          end
        end else begin
          want = resistance_q.pop_front();
          if (res.resistance !== want.resistance || res.status !== want.status) begin
            errors = errors + 1;
            if (errors <= 10) begin
              $display("mismatch: expected resistance %h status %0d, got resistance %h status %0d",
                       want.resistance, want.status, res.resistance, res.status);
            end
          end
        end
      end
      if (cmd_valid && cmd_ready) begin
        if (cmd.func == iarc_pkg::FUNC_MEASURE) begin
          resistance_q.push_back(calc_resistance(cmd));
        end else if (cmd.range_sel >= 3'd1 && cmd.range_sel <= iarc_pkg::RANGE_COUNT &&
                     cmd.point_index < iarc_pkg::POINTS_PER_RANGE) begin
          idx = (cmd.range_sel - 1) * iarc_pkg::POINTS_PER_RANGE + cmd.point_index;
          volt_tab[idx] = cmd.cal_voltage;
          adc_tab[idx]  = cmd.cal_adc;
        end
      end
      pending <= resistance_q.size();
    end
  end

endmodule

>>> sim/insulation_resistance_calibrated_core_tb.sv
// testbench top: clock, reset, command and result traffic, verdict
`timescale 1ns / 1ps

module insulation_resistance_calibrated_core_tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 100;
  localparam int PHASE_ITEMS  = 290;

  logic           clk = 1'b0;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_ready;
  iarc_pkg::cmd_t cmd;
  logic           res_valid;
  logic           res_ready;
  iarc_pkg::res_t res;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int recv_stall_pct;
  bit pressure_on;
  bit hold_done;
  int hold_left;
  int cycle_count;

  always #5 clk = ~clk;

  insulation_resistance_calibrated_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  iarc_resistance_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .errors    (mismatches),
    .pending   (outstanding)
  );

  function automatic iarc_pkg::cmd_t write_beat(input logic [2:0] rs, input logic [3:0] pi,
                                                input logic [15:0] v, input logic [11:0] a);
    iarc_pkg::cmd_t c;
    c.func         = iarc_pkg::FUNC_WRITE;
    c.range_sel    = rs;
    c.point_index  = pi;
    c.cal_voltage  = v;
    c.cal_adc      = a;
    c.gear         = 3'($urandom_range(0, 7));
    c.test_voltage = 16'($urandom_range(0, 65535));
    c.adc_sample   = 12'($urandom_range(0, 4095));
    return c;
  endfunction

  function automatic iarc_pkg::cmd_t measure_beat(input logic [2:0] g, input logic [15:0] v,
                                                  input logic [11:0] a);
    iarc_pkg::cmd_t c;
    c.func         = iarc_pkg::FUNC_MEASURE;
    c.range_sel    = 3'($urandom_range(0, 7));
    c.point_index  = 4'($urandom_range(0, 15));
    c.cal_voltage  = 16'($urandom_range(0, 65535));
    c.cal_adc      = 12'($urandom_range(0, 4095));
    c.gear         = g;
    c.test_voltage = v;
    c.adc_sample   = a;
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_cmd(input iarc_pkg::cmd_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_items(input int count);
    int          done;
    int          kind;
    int          rng;
    int          a;
    int          v;
    bit          rising_volt;
    logic [2:0]  rs;
    logic [3:0]  pi;
    logic [15:0] tv;
    logic [11:0] ad;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        // reload one range with an ascending table
        rng = $urandom_range(1, iarc_pkg::RANGE_COUNT);
        rising_volt = ($urandom_range(0, 1) == 0);
        a = $urandom_range(0, 300);
        v = $urandom_range(0, 3000);
        for (int p = 0; p < iarc_pkg::POINTS_PER_RANGE; p++) begin
          if (!rising_volt) v = $urandom_range(0, 65535);
          push_cmd(write_beat(3'(rng), 4'(p), 16'(v), 12'(a)));
          a = a + $urandom_range(1, 450);
          if (a > 4095) a = 4095;
          v = v + $urandom_range(0, 7000);
          if (v > 65535) v = 65535;
        end
        done = done + iarc_pkg::POINTS_PER_RANGE;
      end else if (kind < 12) begin
        rs = 3'($urandom_range(0, 7));
        pi = 4'($urandom_range(0, 15));
        push_cmd(write_beat(rs, pi, 16'($urandom_range(0, 65535)),
                            12'($urandom_range(0, 4095))));
        if (rs >= 3'd1 && rs <= iarc_pkg::RANGE_COUNT && pi < iarc_pkg::POINTS_PER_RANGE) done++;
      end else begin
        kind = $urandom_range(0, 99);
        if (kind < 10) tv = 16'd0;
        else if (kind < 20) tv = 16'hFFFF;
        else tv = 16'($urandom_range(0, 65535));
        kind = $urandom_range(0, 99);
        if (kind < 15) ad = 12'($urandom_range(0, 12));
        else if (kind < 25) ad = 12'hFFF;
        else ad = 12'($urandom_range(0, 4095));
        push_cmd(measure_beat(3'($urandom_range(0, 7)), tv, ad));
        done++;
      end
    end
  endtask

  // result side: random stalls plus one long hold-off under pressure
  initial begin
    res_ready = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        res_ready <= 1'b0;
      end else if (pressure_on && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        res_ready <= 1'b0;
      end else begin
        res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          v;
    int          a;
    cmd_valid      = 1'b0;
    cmd            = '0;
    rst            = 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_on    = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every table entry before anything is measured
    for (int r = 1; r <= iarc_pkg::RANGE_COUNT; r++) begin
      for (int p = 0; p < iarc_pkg::POINTS_PER_RANGE; p++) begin
        case (r)
          1: begin
            a = 200 + 400 * p;
            v = 1000 + 1000 * p;
          end
          2: begin
            a = (p == 9) ? 2400 : 300 * p;
            v = 5000 + 3000 * p;
          end
          3: begin
            a = (p == 9) ? 2500 : 100 + 350 * p;
            v = 1000 + 1000 * p;
          end
          default: begin
            a = (p == 9) ? 3080 : 100 + 360 * p;
            v = (p == 0) ? 1 : ((p == 9) ? 100 : 7000 * p);
          end
        endcase
        push_cmd(write_beat(3'(r), 4'(p), 16'(v), 12'(a)));
      end
    end

    push_cmd(measure_beat(3'd0, 16'd1000, 12'd0));
    push_cmd(measure_beat(3'd0, 16'hFFFF, 12'd5));
    push_cmd(measure_beat(3'd1, 16'd5000, 12'd10));
    push_cmd(measure_beat(3'd1, 16'd5000, 12'd11));
    push_cmd(measure_beat(3'd1, 16'd5000, 12'd200));
    push_cmd(measure_beat(3'd1, 16'd5000, 12'd201));
    push_cmd(measure_beat(3'd1, 16'hFFFF, 12'd2000));
    push_cmd(measure_beat(3'd1, 16'd0, 12'd2500));
    push_cmd(measure_beat(3'd1, 16'd12345, 12'hFFF));
    push_cmd(measure_beat(3'd2, 16'd30000, 12'd0));
    push_cmd(measure_beat(3'd2, 16'd30000, 12'd3000));
    push_cmd(measure_beat(3'd2, 16'd30000, 12'd1000));
    push_cmd(measure_beat(3'd3, 16'd40000, 12'hFFF));
    push_cmd(measure_beat(3'd3, 16'd40000, 12'd1500));
    push_cmd(measure_beat(3'd4, 16'hFFFF, 12'd100));
    push_cmd(measure_beat(3'd4, 16'd20000, 12'hFFF));
    push_cmd(measure_beat(3'd4, 16'd100, 12'd1000));
    push_cmd(measure_beat(3'd5, 16'd20000, 12'd2000));
    push_cmd(measure_beat(3'd6, 16'd20000, 12'd2000));
    push_cmd(measure_beat(3'd7, 16'hFFFF, 12'hFFF));
    // out-of-range write addresses leave the tables alone
    push_cmd(write_beat(3'd0, 4'd3, 16'd1, 12'd1));
    push_cmd(write_beat(3'd5, 4'd0, 16'd1, 12'd1));
    push_cmd(write_beat(3'd1, 4'd10, 16'd1, 12'd1));
    push_cmd(write_beat(3'd7, 4'd15, 16'd1, 12'd1));
    push_cmd(measure_beat(3'd1, 16'd5000, 12'd1000));

    random_items(PHASE_ITEMS);
    send_idle_pct = 54;
    random_items(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    random_items(PHASE_ITEMS);
    send_idle_pct  = 11;
    recv_stall_pct = 11;
    random_items(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_on    = 1'b1;
    random_items(PHASE_ITEMS);

    cmd_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
